// ----- src/dpc_pkg.sv -----
// Package with shared types, constants and register codes for the damper controller.
`default_nettype none
package dpc_pkg;

    // Default widths of the temperature fields and of the fire tick counter.
    localparam int TEMP_WIDTH_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 4;

    // Fixed register widths.
    localparam int DEADBAND_W = 12;
    localparam int GAIN_W     = 6;
    localparam int STEP_W     = 7;
    localparam int CONFIRM_W  = 4;
    localparam int POS_W      = 7;
    localparam int MODE_W     = 3;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    // Reset values of the configuration registers.
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 12'd16;
    localparam logic [GAIN_W-1:0]     GAIN_RST     = 6'd5;
    localparam logic [STEP_W-1:0]     STEP_RST     = 7'd15;
    localparam logic [CONFIRM_W-1:0]  CONFIRM_RST  = 4'd3;
    localparam logic [POS_W-1:0]      MAX_OPEN_RST = 7'd100;

    // Movement arithmetic: fraction bits of the temperature and the movement cap.
    localparam int FRAC_BITS = 4;
    localparam int MOVE_W    = 11;
    localparam logic [MOVE_W-1:0] MOVE_CAP = 11'd1024;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEADBAND   = 3'd0,
        CFG_GAIN       = 3'd1,
        CFG_STEP_LIMIT = 3'd2,
        CFG_CONFIRM    = 3'd3,
        CFG_MAX_OPEN   = 3'd4
    } cfg_index_t;

    // Result modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_FIRE  = 3'd0,
        MODE_OFF   = 3'd1,
        MODE_HOLD  = 3'd2,
        MODE_OPEN  = 3'd3,
        MODE_CLOSE = 3'd4
    } mode_t;

    // Configuration register set.
    typedef struct packed {
        logic [DEADBAND_W-1:0] deadband;
        logic [GAIN_W-1:0]     gain;
        logic [STEP_W-1:0]     step_limit;
        logic [CONFIRM_W-1:0]  confirm_count;
        logic [POS_W-1:0]      max_open;
    } cfg_t;

endpackage
`default_nettype wire

// ----- src/dpc_fire_filter.sv -----
// Fire signal debounce: saturating consecutive-tick counter and alarm latch.
`default_nettype none
module dpc_fire_filter #(
    parameter int COUNT_WIDTH = dpc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           advance,
    input  wire logic                           fire_raw,
    input  wire logic [dpc_pkg::CONFIRM_W-1:0]  confirm_count,
    output logic                                alarm
);

    localparam int CMP_W = (COUNT_WIDTH > dpc_pkg::CONFIRM_W) ?
                           COUNT_WIDTH : dpc_pkg::CONFIRM_W;

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   latch_reg;
    logic                   latch_next;
    logic [COUNT_WIDTH-1:0] count_inc;

    always_comb
    begin
        count_inc = (count_reg == {COUNT_WIDTH{1'b1}}) ? count_reg :
                    count_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        if (fire_raw)
        begin
            count_next = count_inc;
            latch_next = latch_reg ||
                (CMP_W'(count_inc) >= CMP_W'(confirm_count));
        end
        else
        begin
            count_next = '0;
            latch_next = 1'b0;
        end
    end

    assign alarm = latch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            latch_reg <= 1'b0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            latch_reg <= latch_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/dpc_position_unit.sv -----
// Damper position register with deadband, proportional move, rate limit and clamp.
`default_nettype none
module dpc_position_unit #(
    parameter int TEMP_WIDTH = dpc_pkg::TEMP_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic signed [TEMP_WIDTH-1:0]  measured_temp,
    input  wire logic signed [TEMP_WIDTH-1:0]  target_temp,
    input  wire logic                          enabled,
    input  wire logic                          alarm,
    input  wire dpc_pkg::cfg_t                 cfg,
    output logic [dpc_pkg::POS_W-1:0]          position,
    output dpc_pkg::mode_t                     mode
);

    localparam int DIFF_W = TEMP_WIDTH + 1;
    localparam int CMP_W  = (DIFF_W > dpc_pkg::DEADBAND_W) ? DIFF_W : dpc_pkg::DEADBAND_W;
    localparam int PROD_W = DIFF_W + dpc_pkg::GAIN_W;
    localparam int SUM_W  = dpc_pkg::MOVE_W + 2;
    localparam int POS_W  = dpc_pkg::POS_W;

    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic signed [DIFF_W-1:0] err;
    logic [DIFF_W-1:0]        mag;
    logic [PROD_W-1:0]        prod;
    logic [PROD_W-1:0]        prod_shift;
    logic [dpc_pkg::MOVE_W-1:0] move;
    logic signed [SUM_W-1:0]  sum;
    logic [POS_W-1:0]         desired;
    logic signed [POS_W:0]    dlt;
    logic signed [POS_W:0]    step_lim;
    logic signed [POS_W:0]    delta;
    logic signed [POS_W+1:0]  nxt;

    always_comb
    begin
        err        = DIFF_W'(measured_temp) - DIFF_W'(target_temp);
        mag        = err[DIFF_W-1] ? DIFF_W'(-err) : DIFF_W'(err);
        prod       = PROD_W'(mag) * PROD_W'(cfg.gain);
        prod_shift = prod >> dpc_pkg::FRAC_BITS;
        move       = (prod_shift > PROD_W'(dpc_pkg::MOVE_CAP)) ? dpc_pkg::MOVE_CAP :
                     prod_shift[dpc_pkg::MOVE_W-1:0];
        sum        = err[DIFF_W-1] ? (SUM_W'(pos_reg) - SUM_W'(move)) :
                                     (SUM_W'(pos_reg) + SUM_W'(move));

        if (alarm)
        begin
            desired = '0;
            mode    = dpc_pkg::MODE_FIRE;
        end
        else if (!enabled)
        begin
            desired = '0;
            mode    = dpc_pkg::MODE_OFF;
        end
        else if (CMP_W'(mag) <= CMP_W'(cfg.deadband))
        begin
            desired = pos_reg;
            mode    = dpc_pkg::MODE_HOLD;
        end
        else
        begin
            if (sum < 0)
                desired = '0;
            else if (sum > $signed(SUM_W'(cfg.max_open)))
                desired = cfg.max_open;
            else
                desired = sum[POS_W-1:0];
            mode = err[DIFF_W-1] ? dpc_pkg::MODE_CLOSE : dpc_pkg::MODE_OPEN;
        end

        // Rate limit the change, then clamp the new position to the open range.
        dlt      = $signed({1'b0, desired}) - $signed({1'b0, pos_reg});
        step_lim = $signed({1'b0, cfg.step_limit});
        if (dlt > step_lim)
            delta = step_lim;
        else if (dlt < -step_lim)
            delta = -step_lim;
        else
            delta = dlt;
        nxt = $signed({2'b00, pos_reg}) + $signed({delta[POS_W], delta});
        if (nxt < 0)
            pos_next = '0;
        else if (nxt > $signed({2'b00, cfg.max_open}))
            pos_next = cfg.max_open;
        else
            pos_next = nxt[POS_W-1:0];
    end

    assign position = pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (advance)
            pos_reg <= pos_next;
    end

endmodule
`default_nettype wire

// ----- src/damper_position_controller_core.sv -----
// Top level of the damper position controller: registers, handshakes and checks.
//
// Usage: each request on the input channel (in_valid / in_stall) carries one
// control tick: measured and target temperature, the raw fire signal and the
// system-on flag. Each request produces exactly one result on the output
// channel (out_valid / out_stall): new position, fire_confirmed and mode.
// A request is taken into the input register, and the result is computed by
// single-pass logic on its way into the output register, where it is offered.
// One request per cycle is taken in steady state while the receiver does not
// stall; the rate is set by the single-pass update of the kept position and
// fire counter. When the receiver stalls, the result holds in the output
// register and one more request can still be taken into the input register;
// only when both are full does in_stall rise.
// Configuration writes use cfg_valid / cfg_ready (always ready) with a
// register index and data; they are to be made while no request is in flight.
// Reset clears the position, the fire counter, the alarm latch and both
// pipeline valids, and loads the configuration registers with their defaults.
`default_nettype none
module damper_position_controller_core #(
    parameter int TEMP_WIDTH  = dpc_pkg::TEMP_WIDTH_DEF,
    parameter int COUNT_WIDTH = dpc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [TEMP_WIDTH-1:0]      measured_temp,
    input  wire logic signed [TEMP_WIDTH-1:0]      target_temp,
    input  wire logic                              fire_raw,
    input  wire logic                              enabled,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [dpc_pkg::POS_W-1:0]              position,
    output logic                                   fire_confirmed,
    output logic [dpc_pkg::MODE_W-1:0]             mode,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [dpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration registers.
    dpc_pkg::cfg_t cfg_reg;

    // Input register stage.
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic signed [TEMP_WIDTH-1:0]  meas_reg;
    logic signed [TEMP_WIDTH-1:0]  targ_reg;
    logic                          fire_reg;
    logic                          enabled_reg;

    // Output register stage.
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [dpc_pkg::POS_W-1:0]     position_reg;
    logic                          alarm_out_reg;
    dpc_pkg::mode_t                mode_reg;

    logic                          in_take;
    logic                          out_free;
    logic                          advance;
    logic                          alarm;
    logic [dpc_pkg::POS_W-1:0]     pos_calc;
    dpc_pkg::mode_t                mode_calc;

    // The output register can take a new result when it is empty or being read.
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            meas_reg    <= measured_temp;
            targ_reg    <= target_temp;
            fire_reg    <= fire_raw;
            enabled_reg <= enabled;
        end
        if (advance)
        begin
            position_reg  <= pos_calc;
            alarm_out_reg <= alarm;
            mode_reg      <= mode_calc;
        end
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband      <= dpc_pkg::DEADBAND_RST;
            cfg_reg.gain          <= dpc_pkg::GAIN_RST;
            cfg_reg.step_limit    <= dpc_pkg::STEP_RST;
            cfg_reg.confirm_count <= dpc_pkg::CONFIRM_RST;
            cfg_reg.max_open      <= dpc_pkg::MAX_OPEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dpc_pkg::CFG_DEADBAND: cfg_reg.deadband <= cfg_data;
                dpc_pkg::CFG_GAIN:     cfg_reg.gain <= cfg_data[dpc_pkg::GAIN_W-1:0];
                dpc_pkg::CFG_STEP_LIMIT:
                    cfg_reg.step_limit <= cfg_data[dpc_pkg::STEP_W-1:0];
                dpc_pkg::CFG_CONFIRM:
                    cfg_reg.confirm_count <= cfg_data[dpc_pkg::CONFIRM_W-1:0];
                dpc_pkg::CFG_MAX_OPEN: cfg_reg.max_open <= cfg_data[dpc_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    dpc_fire_filter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fire (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .fire_raw      (fire_reg),
        .confirm_count (cfg_reg.confirm_count),
        .alarm         (alarm)
    );

    dpc_position_unit #(
        .TEMP_WIDTH (TEMP_WIDTH)
    ) u_pos (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .measured_temp (meas_reg),
        .target_temp   (targ_reg),
        .enabled       (enabled_reg),
        .alarm         (alarm),
        .cfg           (cfg_reg),
        .position      (pos_calc),
        .mode          (mode_calc)
    );

    assign out_valid      = out_valid_reg;
    assign position       = position_reg;
    assign fire_confirmed = alarm_out_reg;
    assign mode           = mode_reg;

`ifndef SYNTHESIS
    // A delivered position never exceeds the configured upper clamp.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (position_reg <= cfg_reg.max_open))
        else $error("position above max_open");

    // The fire override mode is reported exactly when the alarm is confirmed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (alarm_out_reg == (mode_reg == dpc_pkg::MODE_FIRE)))
        else $error("mode and fire_confirmed disagree");

    // Input back-pressure only when both register stages are occupied and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with free space");

    // A result that was waiting on a stall is still there in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(position_reg)))
        else $error("stalled result lost");
`endif

endmodule
`default_nettype wire

// ----- tb/damper_position_controller_core_tb.sv -----
// Testbench for the damper position controller core: random and directed ticks, self-checking.
`timescale 1ns / 1ps

// Every request to the controller is one control tick. The driver below feeds ticks from
// a queue that the stimulus process fills. Each tick is folded into a local copy of the
// controller state the moment it is accepted, and the expected result is queued. The
// monitor pops that queue for every accepted result and compares position, alarm flag and
// mode. Configuration is rewritten only while the controller is drained.
module damper_position_controller_core_tb;
    import dpc_pkg::*;

    localparam int TW = TEMP_WIDTH_DEF;
    localparam int CW = COUNT_WIDTH_DEF;
    localparam int TICKS_PER_PHASE = 200;

    typedef struct {
        logic signed [TW-1:0] measured;
        logic signed [TW-1:0] target;
        logic                 fire;
        logic                 on;
    } damper_tick_t;

    typedef struct {
        logic [POS_W-1:0] position;
        logic             confirmed;
        mode_t            mode;
    } damper_result_t;

    // Clock, reset and every input of the controller start at a known value.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic signed [TW-1:0] measured_temp = '0;
    logic signed [TW-1:0] target_temp = '0;
    logic fire_raw = 1'b0;
    logic enabled = 1'b0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic in_stall;
    logic out_valid;
    logic [POS_W-1:0] position;
    logic fire_confirmed;
    logic [MODE_W-1:0] mode;
    logic cfg_ready;

    damper_position_controller_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .measured_temp  (measured_temp),
        .target_temp    (target_temp),
        .fire_raw       (fire_raw),
        .enabled        (enabled),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .position       (position),
        .fire_confirmed (fire_confirmed),
        .mode           (mode),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the configuration registers, loaded with the reset defaults.
    logic [DEADBAND_W-1:0] deadband_r   = DEADBAND_RST;
    logic [GAIN_W-1:0]     gain_r       = GAIN_RST;
    logic [STEP_W-1:0]     step_limit_r = STEP_RST;
    logic [CONFIRM_W-1:0]  confirm_r    = CONFIRM_RST;
    logic [POS_W-1:0]      max_open_r   = MAX_OPEN_RST;

    // Shadow of the controller state: kept position, fire tick counter and alarm latch.
    logic [POS_W-1:0] damper_pos = '0;
    logic [CW-1:0]    fire_ticks = '0;
    logic             alarm_on   = 1'b0;

    damper_tick_t   pending_ticks[$];
    damper_result_t expected_results[$];

    int  fail_count = 0;
    bit  quiet = 1'b0;        // when set, neither side inserts random gaps
    int  squeeze_req = 0;     // bumped by the stimulus to ask for a long receiver hold-off
    int  squeeze_seen = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    int  fire_run_left = 0;

    function automatic int bound(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Applies one control tick to the shadow state and returns what the controller
    // must report for it. The fire counter is updated first, so the alarm can be
    // confirmed on the very tick that reaches the confirm count.
    function automatic damper_result_t advance_damper(damper_tick_t t);
        damper_result_t res;
        int err;
        int mag;
        int move;
        int last;
        int top;
        int step;
        int desired;
        int delta;
        int next_pos;
        mode_t m;

        if (t.fire)
        begin
            if (fire_ticks != {CW{1'b1}})
                fire_ticks = fire_ticks + 1'b1;
            if (fire_ticks >= confirm_r)
                alarm_on = 1'b1;
        end
        else
        begin
            fire_ticks = '0;
            alarm_on = 1'b0;
        end

        last = int'(damper_pos);
        top = int'(max_open_r);
        step = int'(step_limit_r);

        if (alarm_on)
        begin
            desired = 0;
            m = MODE_FIRE;
        end
        else if (!t.on)
        begin
            desired = 0;
            m = MODE_OFF;
        end
        else
        begin
            err = int'(t.measured) - int'(t.target);
            mag = (err < 0) ? -err : err;
            if (mag <= int'(deadband_r))
            begin
                desired = last;
                m = MODE_HOLD;
            end
            else
            begin
                // Whole percent of movement: error times gain, fraction bits dropped.
                move = (mag * int'(gain_r)) >>> FRAC_BITS;
                if (move > int'(MOVE_CAP))
                    move = int'(MOVE_CAP);
                if (err > 0)
                begin
                    desired = bound(last + move, 0, top);
                    m = MODE_OPEN;
                end
                else
                begin
                    desired = bound(last - move, 0, top);
                    m = MODE_CLOSE;
                end
            end
        end

        // Rate limit, then the clamp; the clamp also pulls a stored position down
        // when max_open has been lowered below it.
        delta = bound(desired - last, -step, step);
        next_pos = bound(last + delta, 0, top);
        damper_pos = POS_W'(next_pos);

        res.position = damper_pos;
        res.confirmed = alarm_on;
        res.mode = m;
        return res;
    endfunction

    // Sender gaps: mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Driver: a request is accepted at an edge with in_valid high and in_stall low.
    // A stalled request is held unchanged; otherwise the next tick is offered once
    // the current gap has run out.
    always @(posedge clk or negedge rst_n)
    begin
        damper_tick_t t;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                t.measured = measured_temp;
                t.target = target_temp;
                t.fire = fire_raw;
                t.on = enabled;
                expected_results.push_back(advance_damper(t));
            end

            if (in_valid && in_stall)
            begin
                // Hold the stalled request as it is.
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_ticks.size() > 0)
            begin
                t = pending_ticks.pop_front();
                measured_temp <= t.measured;
                target_temp <= t.target;
                fire_raw <= t.fire;
                enabled <= t.on;
                in_valid <= 1'b1;
                gap_left <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver: checks each accepted result against the oldest expectation
    // and drives out_stall. A new squeeze request starts a long hold-off, counted here,
    // during which the controller fills up and has to stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        damper_result_t exp_res;
        int r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: position %0d mode %0d",
                           position, mode);
                    fail_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (position !== exp_res.position)
                    begin
                        $error("position mismatch: expected %0d, actual %0d",
                               exp_res.position, position);
                        fail_count++;
                    end
                    if (fire_confirmed !== exp_res.confirmed)
                    begin
                        $error("fire_confirmed mismatch: expected %0d, actual %0d",
                               exp_res.confirmed, fire_confirmed);
                        fail_count++;
                    end
                    if (mode !== exp_res.mode)
                    begin
                        $error("mode mismatch: expected %0d, actual %0d",
                               exp_res.mode, mode);
                        fail_count++;
                    end
                end
            end

            if (squeeze_req != squeeze_seen)
            begin
                squeeze_seen <= squeeze_req;
                hold_left <= 150;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    out_stall <= 1'b0;
                end
                else if (r < 97)
                begin
                    out_stall <= 1'b1;
                    hold_left <= $urandom_range(0, 2);
                end
                else
                begin
                    out_stall <= 1'b1;
                    hold_left <= $urandom_range(10, 40);
                end
            end
        end
    end

    // Writes one configuration register and mirrors it in the shadow copy.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_DEADBAND:   deadband_r = val[DEADBAND_W-1:0];
            CFG_GAIN:       gain_r = val[GAIN_W-1:0];
            CFG_STEP_LIMIT: step_limit_r = val[STEP_W-1:0];
            CFG_CONFIRM:    confirm_r = val[CONFIRM_W-1:0];
            CFG_MAX_OPEN:   max_open_r = val[POS_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued tick was taken and every result has come back, then
    // lets the two-stage pipeline settle. Sampling at the falling edge avoids racing
    // the driver at the rising edge.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_tick(int meas, int targ, bit fire, bit on);
        damper_tick_t t;
        t.measured = TW'(meas);
        t.target = TW'(targ);
        t.fire = fire;
        t.on = on;
        pending_ticks.push_back(t);
    endtask

    // Random tick: mostly errors near the deadband edge or within 300 LSB (18.75 degrees) of
    // the setpoint, some fully random temperatures. The fire signal comes in runs of
    // random length so that confirmation and counter saturation are both reached.
    task automatic queue_random_tick();
        int r;
        int targ;
        int meas;
        int db;
        bit fire;
        r = $urandom_range(0, 99);
        targ = int'($signed(TW'($urandom)));
        db = int'(deadband_r);
        if (r < 25)
            meas = int'($signed(TW'($urandom)));
        else if (r < 70)
            meas = targ + $urandom_range(0, 600) - 300;
        else if (r < 85)
            meas = targ + db + $urandom_range(0, 4) - 2;
        else
            meas = targ - db - $urandom_range(0, 4) + 2;

        if (fire_run_left > 0)
        begin
            fire = 1'b1;
            fire_run_left--;
        end
        else if ($urandom_range(0, 99) < 6)
        begin
            fire = 1'b1;
            fire_run_left = $urandom_range(0, 19);
        end
        else
        begin
            fire = 1'b0;
        end

        queue_tick(meas, targ, fire, $urandom_range(0, 99) < 92);
    endtask

    // One phase: drain, reprogram every register, then queue a batch of random ticks.
    task automatic run_phase(int db, int gn, int st, int cf, int mo, bit calm, bit squeeze);
        wait_drained();
        write_reg(CFG_DEADBAND, CFG_DATA_W'(db));
        write_reg(CFG_GAIN, CFG_DATA_W'(gn));
        write_reg(CFG_STEP_LIMIT, CFG_DATA_W'(st));
        write_reg(CFG_CONFIRM, CFG_DATA_W'(cf));
        write_reg(CFG_MAX_OPEN, CFG_DATA_W'(mo));
        quiet = calm;
        for (int i = 0; i < TICKS_PER_PHASE; i++)
            queue_random_tick();
        if (squeeze)
            squeeze_req++;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks under the reset defaults (deadband 16, gain 5, step 15,
        // confirm 3, max open 100).
        queue_tick(0, 0, 0, 1);              // no error: hold
        queue_tick(17, 0, 0, 1);             // just past the band, hot: opens by 5
        queue_tick(0, 17, 0, 1);             // just past the band, cold: closes by 5
        queue_tick(16, 0, 0, 1);             // on the band edge, hot side: hold
        queue_tick(0, 16, 0, 1);             // on the band edge, cold side: hold
        queue_tick(32767, -32768, 0, 1);     // largest positive error, movement capped
        queue_tick(32767, -32768, 0, 1);
        queue_tick(32767, -32768, 0, 1);
        queue_tick(-32768, 32767, 0, 1);     // largest negative error
        queue_tick(32767, 32767, 0, 1);
        queue_tick(-32768, -32768, 0, 1);
        queue_tick(32767, -32768, 0, 1);
        queue_tick(32767, -32768, 0, 0);     // system off drives toward closed
        queue_tick(32767, -32768, 0, 1);
        queue_tick(1000, 0, 1, 1);           // fire ticks one and two: not yet confirmed
        queue_tick(1000, 0, 1, 1);
        queue_tick(1000, 0, 1, 1);           // third tick confirms the alarm
        queue_tick(1000, 0, 1, 0);
        queue_tick(1000, 0, 0, 1);           // fire gone: counter and latch clear
        queue_tick(1000, 0, 1, 1);           // counting restarts from one
        queue_tick(1000, 0, 1, 1);
        queue_tick(1000, 0, 0, 1);
        queue_tick(-1000, 0, 1, 1);

        // Extremes of every register: zero deadband with full gain, widest deadband
        // with zero gain, zero step, zero confirm count, max open above 100 and at zero.
        run_phase(0, 63, 100, 1, 100, 1'b0, 1'b0);
        run_phase(4095, 0, 1, 15, 1, 1'b0, 1'b0);
        run_phase(16, 5, 0, 0, 127, 1'b1, 1'b0);
        // Open wide, then lower max open under a wide band so held positions get
        // pulled down. The wide-open phase also runs the long receiver hold-off.
        run_phase(8, 20, 127, 2, 127, 1'b1, 1'b1);
        run_phase(4095, 5, 10, 3, 20, 1'b0, 1'b0);
        run_phase(32, 40, 15, 4, 0, 1'b0, 1'b0);
        run_phase($urandom_range(0, 4095), $urandom_range(0, 63), $urandom_range(0, 127),
                  $urandom_range(0, 15), $urandom_range(0, 127), 1'b0, 1'b0);
        run_phase($urandom_range(0, 64), $urandom_range(0, 63), $urandom_range(1, 100),
                  $urandom_range(1, 15), $urandom_range(1, 100), 1'b0, 1'b1);
        run_phase($urandom_range(0, 4095), $urandom_range(0, 63), $urandom_range(0, 127),
                  $urandom_range(0, 15), $urandom_range(0, 127), 1'b0, 1'b0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS damper_position_controller_core");
        else
            $display("FAIL damper_position_controller_core");
        $finish;
    end

    // Run limit, several times the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("FAIL damper_position_controller_core");
        $finish;
    end

endmodule
